// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rstn is low.
`define AVS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while rstn is low.
`define AVS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/avs_pkg.sv =====
// Shared types, codes and constants of the additive oscillator voice.
// No dependencies; the modules of the block refer to it by scoped names.
`default_nettype none

package avs_pkg;

    // Input transaction fields.
    typedef struct packed {
        logic [1:0] mode;
        logic [6:0] note;
    } t_in;

    // Result transaction fields.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               voice_active;
    } t_out;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [2:0]  waveform;
        logic [17:0] sample_rate;
        logic [23:0] attack_samples;
        logic [23:0] decay_samples;
        logic [15:0] sustain_level;
        logic [23:0] release_samples;
    } t_cfg;

    // Input modes.
    localparam logic [1:0] MODE_TICK     = 2'd0;
    localparam logic [1:0] MODE_NOTE_ON  = 2'd1;
    localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
    localparam logic [1:0] MODE_UNUSED   = 2'd3;

    // Waveform codes.
    localparam logic [2:0] WAVE_SILENT = 3'd0;
    localparam logic [2:0] WAVE_SINE   = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_SQUARE = 3'd3;
    localparam logic [2:0] WAVE_NOISE  = 3'd4;

    // Register indexes.
    localparam logic [2:0] REG_WAVEFORM = 3'd0;
    localparam logic [2:0] REG_RATE     = 3'd1;
    localparam logic [2:0] REG_ATTACK   = 3'd2;
    localparam logic [2:0] REG_DECAY    = 3'd3;
    localparam logic [2:0] REG_SUSTAIN  = 3'd4;
    localparam logic [2:0] REG_RELEASE  = 3'd5;

    // Register reset values.
    localparam logic [2:0]  RST_WAVEFORM = WAVE_SINE;
    localparam logic [17:0] RST_RATE     = 18'd44100;
    localparam logic [23:0] RST_ATTACK   = 24'd441;
    localparam logic [23:0] RST_DECAY    = 24'd4410;
    localparam logic [15:0] RST_SUSTAIN  = 16'd45875;
    localparam logic [23:0] RST_RELEASE  = 24'd4410;

    // Default sizes.
    localparam int MAX_PARTIALS_DEF    = 1024;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Serial divider sizes: dividend width and its bit-count width.
    localparam int DIV_W  = 50;
    localparam int DIV_LW = 6;

    // Noise generator.
    localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
    localparam logic [31:0] LFSR_MASK = 32'h8020_0003;

    // Partial-sum scale factors, 2/pi and 4/pi in Q16.
    localparam logic signed [17:0] SAW_SCALE    = 18'sd41721;
    localparam logic signed [17:0] SQUARE_SCALE = 18'sd83443;

    // Top-octave frequencies in Q14.16 Hz.
    function automatic logic [29:0] top_octave(input logic [3:0] semi);
        logic [29:0] f;
        unique case (semi)
            4'd0:    f = 30'd548668578;
            4'd1:    f = 30'd581294109;
            4'd2:    f = 30'd615859655;
            4'd3:    f = 30'd652480576;
            4'd4:    f = 30'd691279090;
            4'd5:    f = 30'd732384684;
            4'd6:    f = 30'd775934544;
            4'd7:    f = 30'd822074013;
            4'd8:    f = 30'd870957076;
            4'd9:    f = 30'd922746880;
            4'd10:   f = 30'd977616272;
            4'd11:   f = 30'd1035748351;
            default: f = 30'd0;
        endcase
        return f;
    endfunction

    // Note frequency: octave by reciprocal multiply (n*43 >> 9 equals n/12 for n < 128).
    function automatic logic [29:0] note_freq(input logic [6:0] n);
        logic [12:0] m;
        logic [3:0]  oct;
        logic [3:0]  semi;
        m    = 13'(n) * 13'd43;
        oct  = m[12:9];
        semi = 4'(n - 7'(7'(oct) * 7'd12));
        return top_octave(semi) >> (4'd10 - oct);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/avs_front.sv =====
// Front end: accepts input transactions, drops unused modes, queues commands.
// Depends on avs_pkg.
`default_nettype none

module avs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire avs_pkg::t_in  i_data,
    output logic               o_cmd_valid,
    output avs_pkg::t_in       o_cmd,
    input  wire logic          i_cmd_pop
);

    avs_pkg::t_in r_fifo [2];
    logic         r_wr_ptr;
    logic         r_rd_ptr;
    logic [1:0]   r_count;
    logic         push;

    // The queue is full at two entries.
    assign o_stall     = (r_count == 2'd2);
    assign o_cmd_valid = (r_count != 2'd0);
    assign o_cmd       = r_fifo[r_rd_ptr];
    assign push        = i_valid && !o_stall && (i_data.mode != avs_pkg::MODE_UNUSED);

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= i_data;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({push, i_cmd_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/avs_div.sv =====
// Restoring serial divider, one quotient bit per cycle over the low i_len bits.
// Depends on avs_pkg for its sizes.
`default_nettype none

module avs_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [avs_pkg::DIV_W-1:0]  i_num,
    input  wire logic [31:0]                i_den,
    input  wire logic [avs_pkg::DIV_LW-1:0] i_len,
    output logic                            o_done,
    output logic [avs_pkg::DIV_W-1:0]       o_quo
);

    localparam int DW = avs_pkg::DIV_W;
    localparam int LW = avs_pkg::DIV_LW;

    logic          r_busy;
    logic          r_done;
    logic [LW-1:0] r_cnt;
    logic [31:0]   r_rem;
    logic [31:0]   r_den;
    logic [DW-1:0] r_quo;
    logic [32:0]   rem_sh;
    logic          fits;

    assign rem_sh = {r_rem, r_quo[DW-1]};
    assign fits   = (rem_sh >= {1'b0, r_den});
    assign o_done = r_done;
    assign o_quo  = r_quo;

    // Operand registers; the dividend is left aligned so that only i_len steps run.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num << (LW'(DW) - i_len);
            r_rem <= 32'd0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(rem_sh - {1'b0, r_den}) : rem_sh[31:0];
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - LW'(1);
                if (r_cnt == LW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/avs_sine.sv =====
// Sine unit: quarter-wave Taylor polynomial in Q30, Horner form on one multiplier.
// Depends on avs_pkg for its default table size.
`default_nettype none

module avs_sine #(
    parameter int SINE_TABLE_BITS = avs_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_phase,
    output logic             o_done,
    output logic signed [15:0] o_y
);

    localparam int FW = SINE_TABLE_BITS - 2;
    localparam logic [31:0] HORN_C [4] = '{
        32'd5026995, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_X2    = 4'b0010,
        S_HORN  = 4'b0100,
        S_ROUND = 4'b1000
    } t_sstate;

    t_sstate              r_state;
    logic [1:0]           r_k;
    logic [1:0]           r_quad;
    logic [30:0]          r_x;
    logic [30:0]          r_x2;
    logic [61:0]          r_prod;
    logic                 r_done;
    logic signed [15:0]   r_y;

    logic [SINE_TABLE_BITS-1:0] idx;
    logic [30:0]                x_raw;
    logic [30:0]                x;
    logic [31:0]                h_a;
    logic [30:0]                h_b;
    logic [61:0]                hmul;
    logic [32:0]                y_rnd;
    logic [14:0]                y_mag;

    // Table index, quadrant and the folded argument.
    assign idx   = i_phase[31 -: SINE_TABLE_BITS];
    assign x_raw = 31'(idx[FW-1:0]) << (30 - FW);
    assign x     = idx[SINE_TABLE_BITS-2] ? (31'h4000_0000 - x_raw) : x_raw;

    // Shared multiplier operands per step.
    always_comb begin
        h_a = {1'b0, x};
        h_b = x;
        unique case (r_state)
            S_X2: begin
                h_a = 32'd172272;
                h_b = r_prod[60:30];
            end
            S_HORN: begin
                h_a = HORN_C[r_k] - r_prod[61:30];
                h_b = (r_k == 2'd3) ? r_x : r_x2;
            end
            default: begin
                h_a = {1'b0, x};
                h_b = x;
            end
        endcase
    end

    assign hmul  = h_a * h_b;
    assign y_rnd = (33'(r_prod[61:30]) + 33'd16384) >> 15;
    assign y_mag = (y_rnd > 33'd32767) ? 15'h7FFF : y_rnd[14:0];

    assign o_done = r_done;
    assign o_y    = r_y;

    // Step sequence: square, four Horner steps, round.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_X2;
                    end
                end
                S_X2: begin
                    r_k     <= 2'd0;
                    r_state <= S_HORN;
                end
                S_HORN: begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_x    <= x;
            r_quad <= idx[SINE_TABLE_BITS-1 -: 2];
            r_prod <= hmul;
        end else if (r_state == S_X2) begin
            r_x2   <= r_prod[60:30];
            r_prod <= hmul;
        end else if (r_state == S_HORN) begin
            r_prod <= hmul;
        end else if (r_state == S_ROUND) begin
            r_y <= r_quad[1] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
        end
    end

endmodule

`default_nettype wire

// ===== hdl/avs_back.sv =====
// Back end: note setup, waveform and envelope sequencer, result register.
// Depends on avs_pkg, avs_div and avs_sine.
`default_nettype none

module avs_back #(
    parameter int MAX_PARTIALS    = avs_pkg::MAX_PARTIALS_DEF,
    parameter int SINE_TABLE_BITS = avs_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire avs_pkg::t_cfg i_cfg,
    input  wire logic          i_cmd_valid,
    input  wire avs_pkg::t_in  i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output avs_pkg::t_out      o_data
);

    localparam int LW  = $clog2(MAX_PARTIALS + 1);
    localparam int NW  = $clog2(MAX_PARTIALS + 3);
    localparam int AW  = 33 + $clog2(MAX_PARTIALS + 1);
    localparam int PW  = AW + 18;
    localparam int DW  = avs_pkg::DIV_W;
    localparam int DLW = avs_pkg::DIV_LW;

    typedef enum logic [14:0] {
        ST_IDLE  = 15'h0001,
        ST_NDIV1 = 15'h0002,
        ST_NDIV2 = 15'h0004,
        ST_WAVE  = 15'h0008,
        ST_SINW  = 15'h0010,
        ST_PCHK  = 15'h0020,
        ST_PSIN  = 15'h0040,
        ST_PDIV  = 15'h0080,
        ST_SCALE = 15'h0100,
        ST_SAT   = 15'h0200,
        ST_ADV   = 15'h0400,
        ST_EMUL  = 15'h0800,
        ST_EDIV  = 15'h1000,
        ST_APPLY = 15'h2000,
        ST_OUT   = 15'h4000
    } t_state;

    typedef enum logic [1:0] {
        G_ATTACK  = 2'd0,
        G_DECAY   = 2'd1,
        G_RELEASE = 2'd2
    } t_gsel;

    t_state                r_state, n_state;
    logic [31:0]           r_phase;
    logic [31:0]           r_step;
    logic [LW-1:0]         r_limit;
    logic [31:0]           r_since_start;
    logic [31:0]           r_since_rel;
    logic                  r_in_rel;
    logic                  r_sounding;
    logic [31:0]           r_lfsr;
    logic [29:0]           r_freq;
    logic signed [15:0]    r_wave;
    logic signed [AW-1:0]  r_acc;
    logic [NW-1:0]         r_n;
    logic [31:0]           r_pph;
    logic                  r_sneg;
    t_gsel                 r_gsel;
    logic [48:0]           r_eprod;
    logic [23:0]           r_eden;
    logic [16:0]           r_gain;
    logic signed [PW-1:0]  r_sprod;
    logic signed [33:0]    r_mprod;
    logic                  r_out_valid;
    avs_pkg::t_out         r_out;

    logic [17:0]           rate_eff;
    logic [29:0]           freq_now;
    logic                  is_square;
    logic                  out_load;
    logic [31:0]           lfsr_next;
    logic                  div_start;
    logic [DW-1:0]         div_num;
    logic [31:0]           div_den;
    logic [DLW-1:0]        div_len;
    logic                  div_done;
    logic [DW-1:0]         div_quo;
    logic                  sin_start;
    logic [31:0]           sin_phase;
    logic                  sin_done;
    logic signed [15:0]    sin_y;
    logic [14:0]           y_abs;
    logic signed [AW-1:0]  term;
    logic signed [17:0]    scale;
    logic signed [PW-33:0] sh;
    logic [32:0]           a_plus_d;

    // Shared helpers.
    assign rate_eff  = (i_cfg.sample_rate == 18'd0) ? 18'd1 : i_cfg.sample_rate;
    assign freq_now  = avs_pkg::note_freq(i_cmd.note);
    assign is_square = (i_cfg.waveform == avs_pkg::WAVE_SQUARE);
    assign lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? avs_pkg::LFSR_MASK : 32'd0);
    assign y_abs     = sin_y[15] ? 15'(-sin_y) : sin_y[14:0];
    assign term      = $signed(AW'(div_quo[31:0]));
    assign scale     = is_square ? avs_pkg::SQUARE_SCALE : avs_pkg::SAW_SCALE;
    assign sh        = (PW-32)'(r_sprod >>> 32);
    assign a_plus_d  = 33'(i_cfg.attack_samples) + 33'(i_cfg.decay_samples);
    assign out_load  = (r_state == ST_OUT) && (!r_out_valid || !i_stall);
    assign o_cmd_pop = (r_state == ST_IDLE) && i_cmd_valid;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // Divider requests.
    always_comb begin
        div_start = 1'b0;
        div_num   = DW'({freq_now, 16'h0000});
        div_den   = 32'(rate_eff);
        div_len   = DLW'(DW);
        unique case (r_state)
            ST_IDLE: begin
                div_start = i_cmd_valid && (i_cmd.mode == avs_pkg::MODE_NOTE_ON);
            end
            ST_NDIV1: begin
                div_start = div_done;
                div_num   = DW'({rate_eff, 16'h0000});
                div_den   = 32'({r_freq, 1'b0});
            end
            ST_PSIN: begin
                div_start = sin_done;
                div_num   = DW'({y_abs, 16'h0000});
                div_den   = 32'(r_n);
                div_len   = DLW'(32);
            end
            ST_EMUL: begin
                div_start = 1'b1;
                div_num   = DW'(r_eprod);
                div_den   = 32'(r_eden);
            end
            default: div_start = 1'b0;
        endcase
    end

    // Sine requests.
    assign sin_start = ((r_state == ST_WAVE) && (i_cfg.waveform == avs_pkg::WAVE_SINE))
                    || ((r_state == ST_PCHK) && (NW'(r_limit) >= r_n));
    assign sin_phase = (r_state == ST_WAVE) ? r_phase : r_pph;

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid && i_cmd.mode == avs_pkg::MODE_NOTE_ON) begin
                    n_state = ST_NDIV1;
                end else if (i_cmd_valid && i_cmd.mode == avs_pkg::MODE_TICK) begin
                    n_state = ST_WAVE;
                end
            end
            ST_NDIV1: if (div_done) n_state = ST_NDIV2;
            ST_NDIV2: if (div_done) n_state = ST_IDLE;
            ST_WAVE: begin
                priority case (i_cfg.waveform)
                    avs_pkg::WAVE_SINE:   n_state = ST_SINW;
                    avs_pkg::WAVE_SAW:    n_state = ST_PCHK;
                    avs_pkg::WAVE_SQUARE: n_state = ST_PCHK;
                    default:              n_state = ST_ADV;
                endcase
            end
            ST_SINW:  if (sin_done) n_state = ST_ADV;
            ST_PCHK:  n_state = (NW'(r_limit) >= r_n) ? ST_PSIN : ST_SCALE;
            ST_PSIN:  if (sin_done) n_state = ST_PDIV;
            ST_PDIV:  if (div_done) n_state = ST_PCHK;
            ST_SCALE: n_state = ST_SAT;
            ST_SAT:   n_state = ST_ADV;
            ST_ADV: begin
                if (!r_sounding) begin
                    n_state = ST_OUT;
                end else if (!r_in_rel) begin
                    if (r_since_start < 32'(i_cfg.attack_samples)
                        || 33'(r_since_start) < a_plus_d) begin
                        n_state = ST_EMUL;
                    end else begin
                        n_state = ST_APPLY;
                    end
                end else if (r_since_rel >= 32'(i_cfg.release_samples)) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_EMUL;
                end
            end
            ST_EMUL:  n_state = ST_EDIV;
            ST_EDIV:  if (div_done) n_state = ST_APPLY;
            ST_APPLY: n_state = ST_OUT;
            ST_OUT:   if (out_load) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Voice state and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_phase       <= 32'd0;
            r_step        <= 32'd0;
            r_limit       <= '0;
            r_since_start <= 32'd0;
            r_since_rel   <= 32'd0;
            r_in_rel      <= 1'b0;
            r_sounding    <= 1'b0;
            r_lfsr        <= avs_pkg::LFSR_SEED;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cmd_valid && i_cmd.mode == avs_pkg::MODE_NOTE_OFF) begin
                        r_in_rel    <= 1'b1;
                        r_since_rel <= 32'd0;
                    end
                end
                ST_NDIV1: begin
                    if (div_done) begin
                        r_step <= (|div_quo[DW-1:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
                    end
                end
                ST_NDIV2: begin
                    if (div_done) begin
                        r_limit       <= (div_quo > DW'(MAX_PARTIALS)) ? LW'(MAX_PARTIALS)
                                                                      : div_quo[LW-1:0];
                        r_since_start <= 32'd0;
                        r_in_rel      <= 1'b0;
                        r_sounding    <= 1'b1;
                    end
                end
                ST_WAVE: begin
                    if (i_cfg.waveform == avs_pkg::WAVE_NOISE) begin
                        r_lfsr <= lfsr_next;
                    end
                end
                ST_ADV: begin
                    r_phase <= r_phase + r_step;
                    if (r_sounding && r_in_rel) begin
                        if (r_since_rel != 32'hFFFF_FFFF) begin
                            r_since_rel <= r_since_rel + 32'd1;
                        end
                        if (r_since_rel >= 32'(i_cfg.release_samples)) begin
                            r_sounding <= 1'b0;
                        end
                    end
                end
                ST_OUT: begin
                    if (out_load && r_since_start != 32'hFFFF_FFFF) begin
                        r_since_start <= r_since_start + 32'd1;
                    end
                end
                default: r_phase <= r_phase;
            endcase
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_freq <= freq_now;
            end
            ST_WAVE: begin
                r_acc  <= '0;
                r_n    <= NW'(1);
                r_pph  <= r_phase;
                r_wave <= (i_cfg.waveform == avs_pkg::WAVE_NOISE) ? $signed(lfsr_next[15:0])
                                                                  : 16'sd0;
            end
            ST_SINW: begin
                if (sin_done) begin
                    r_wave <= sin_y;
                end
            end
            ST_PSIN: begin
                if (sin_done) begin
                    r_sneg <= sin_y[15];
                end
            end
            ST_PDIV: begin
                if (div_done) begin
                    r_acc <= r_sneg ? (r_acc - term) : (r_acc + term);
                    r_n   <= r_n + (is_square ? NW'(2) : NW'(1));
                    r_pph <= r_pph + (is_square ? {r_phase[30:0], 1'b0} : r_phase);
                end
            end
            ST_SCALE: begin
                r_sprod <= r_acc * scale;
            end
            ST_SAT: begin
                if (sh > 32'sd32767) begin
                    r_wave <= 16'sh7FFF;
                end else if (sh < -32'sd32768) begin
                    r_wave <= -16'sh8000;
                end else begin
                    r_wave <= sh[15:0];
                end
            end
            ST_ADV: begin
                r_gain <= 17'(i_cfg.sustain_level);
                if (!r_in_rel) begin
                    if (r_since_start < 32'(i_cfg.attack_samples)) begin
                        r_eprod <= 49'({r_since_start, 16'h0000});
                        r_eden  <= i_cfg.attack_samples;
                        r_gsel  <= G_ATTACK;
                    end else begin
                        r_eprod <= 49'(r_since_start - 32'(i_cfg.attack_samples))
                                 * 49'(17'h10000 - 17'(i_cfg.sustain_level));
                        r_eden  <= i_cfg.decay_samples;
                        r_gsel  <= G_DECAY;
                    end
                end else begin
                    r_eprod <= 49'(r_since_rel) * 49'(i_cfg.sustain_level);
                    r_eden  <= i_cfg.release_samples;
                    r_gsel  <= G_RELEASE;
                end
            end
            ST_EDIV: begin
                if (div_done) begin
                    case (r_gsel)
                        G_ATTACK: r_gain <= 17'(div_quo);
                        G_DECAY:  r_gain <= 17'h10000 - 17'(div_quo);
                        default:  r_gain <= 17'(i_cfg.sustain_level) - 17'(div_quo);
                    endcase
                end
            end
            ST_APPLY: begin
                r_mprod <= r_wave * $signed({1'b0, r_gain});
            end
            ST_OUT: begin
                if (out_load) begin
                    r_out.sample       <= r_sounding ? r_mprod[31:16] : 16'sd0;
                    r_out.voice_active <= r_sounding;
                end
            end
            default: r_freq <= r_freq;
        endcase
    end

    // Shared divider.
    avs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .i_len   (div_len),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Shared sine unit.
    avs_sine #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sin_start),
        .i_phase (sin_phase),
        .o_done  (sin_done),
        .o_y     (sin_y)
    );

endmodule

`default_nettype wire

// ===== hdl/additive_oscillator_adsr_voice.sv =====
// One synthesizer voice: sine, band-limited saw or square, noise or silence, under a linear
// ADSR envelope. The input channel (i_valid, o_stall, i_data) carries commands:
// mode 0 is a sample tick, mode 1 a note-on with i_data.note, mode 2 a note-off.
// Only ticks produce a result transaction on (o_valid, i_stall, o_data), in order.
// Mode 3 is taken and dropped. Registers are written through the APB port.
// Commands pass through a two-entry queue in front of the sequencer; one command
// is carried out at a time.
// A note-on runs two serial divides over the full 50-bit dividend. A tick runs the
// sine unit for sine, and the divider as well while the envelope is in attack, decay
// or release. Saw and square run, per partial, a check, the sine unit and the divider,
// for up to MAX_PARTIALS partials (1024 by default).
// Reset clears the voice, loads the default registers and seeds the noise LFSR.
// While the receiver stalls, the result is held and the queue still fills.
// Depends on avs_pkg, avs_front and avs_back.
`default_nettype none

module additive_oscillator_adsr_voice #(
    parameter int MAX_PARTIALS    = avs_pkg::MAX_PARTIALS_DEF,
    parameter int SINE_TABLE_BITS = avs_pkg::SINE_TABLE_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire avs_pkg::t_in  i_data,
    output logic               o_valid,
    input  wire logic          i_stall,
    output avs_pkg::t_out      o_data,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    avs_pkg::t_cfg r_cfg;
    logic [2:0]    reg_idx;
    logic          cfg_write;
    logic          cmd_valid;
    avs_pkg::t_in  cmd;
    logic          cmd_pop;

    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.waveform        <= avs_pkg::RST_WAVEFORM;
            r_cfg.sample_rate     <= avs_pkg::RST_RATE;
            r_cfg.attack_samples  <= avs_pkg::RST_ATTACK;
            r_cfg.decay_samples   <= avs_pkg::RST_DECAY;
            r_cfg.sustain_level   <= avs_pkg::RST_SUSTAIN;
            r_cfg.release_samples <= avs_pkg::RST_RELEASE;
        end else if (cfg_write) begin
            unique case (reg_idx)
                avs_pkg::REG_WAVEFORM: r_cfg.waveform        <= pwdata[2:0];
                avs_pkg::REG_RATE:     r_cfg.sample_rate     <= pwdata[17:0];
                avs_pkg::REG_ATTACK:   r_cfg.attack_samples  <= pwdata[23:0];
                avs_pkg::REG_DECAY:    r_cfg.decay_samples   <= pwdata[23:0];
                avs_pkg::REG_SUSTAIN:  r_cfg.sustain_level   <= pwdata[15:0];
                avs_pkg::REG_RELEASE:  r_cfg.release_samples <= pwdata[23:0];
                default:               r_cfg                 <= r_cfg;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (reg_idx)
            avs_pkg::REG_WAVEFORM: prdata = 32'(r_cfg.waveform);
            avs_pkg::REG_RATE:     prdata = 32'(r_cfg.sample_rate);
            avs_pkg::REG_ATTACK:   prdata = 32'(r_cfg.attack_samples);
            avs_pkg::REG_DECAY:    prdata = 32'(r_cfg.decay_samples);
            avs_pkg::REG_SUSTAIN:  prdata = 32'(r_cfg.sustain_level);
            avs_pkg::REG_RELEASE:  prdata = 32'(r_cfg.release_samples);
            default:               prdata = 32'd0;
        endcase
    end

    // Command intake and queue.
    avs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Voice sequencer.
    avs_back #(
        .MAX_PARTIALS    (MAX_PARTIALS),
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data)
    );

endmodule

`default_nettype wire

// ===== hdl/avs_checker.sv =====
// Port-level checks of the voice, attached to the top level by a bind.
// Depends on avs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module avs_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          o_stall,
    input wire logic          o_valid,
    input wire logic          i_stall,
    input wire avs_pkg::t_out o_data,
    input wire logic          pready
);

    // A stalled result stays offered.
    `AVS_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_valid && i_stall, o_valid)

    // A stalled result keeps its value.
    `AVS_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_valid && i_stall, $stable(o_data))

    // A voice that is not sounding gives silence.
    `AVS_ASSERT_NOW(a_silent_zero, i_clk, i_rst_n, o_valid && !o_data.voice_active, o_data.sample == 16'sd0)

    // Reset empties the result register and the command queue.
    `AVS_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid && !o_stall)

    // The register port never waits.
    `AVS_ASSERT_NOW(a_pready, i_clk, i_rst_n, 1'b1, pready)

endmodule

bind additive_oscillator_adsr_voice avs_checker u_avs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_data  (o_data),
    .pready  (pready)
);

`default_nettype wire

// ===== dv/additive_oscillator_adsr_voice_test.sv =====
// Self-checking testbench of the additive oscillator voice with ADSR envelope.
// Depends on avs_pkg and the additive_oscillator_adsr_voice top level.

// Tracks voice state and holds the samples the voice should produce, oldest first.
class voice_scoreboard;
    localparam int PARTIAL_CAP = 1024;
    localparam int TABLE_BITS  = 10;

    bit [31:0] octave_hz [12] = '{
        548668578, 581294109, 615859655, 652480576, 691279090, 732384684,
        775934544, 822074013, 870957076, 922746880, 977616272, 1035748351};

    bit [2:0]  wave_sel;
    bit [17:0] rate;
    bit [23:0] attack_len, decay_len, release_len;
    bit [15:0] sustain;
    bit [31:0] phase, phase_step, since_start, since_release, lfsr;
    bit [10:0] partials;
    bit        in_release, sounding;
    avs_pkg::t_out samples_due[$];
    int        mismatches;

    function new();
        wave_sel = avs_pkg::WAVE_SINE;
        rate = 18'd44100;
        attack_len = 24'd441;
        decay_len = 24'd4410;
        sustain = 16'd45875;
        release_len = 24'd4410;
        phase = 0; phase_step = 0; since_start = 0; since_release = 0;
        partials = 0; in_release = 0; sounding = 0;
        lfsr = 32'h0000_ACE1;
        mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] value);
        case (idx)
            avs_pkg::REG_WAVEFORM: wave_sel = value[2:0];
            avs_pkg::REG_RATE:     rate = value[17:0];
            avs_pkg::REG_ATTACK:   attack_len = value[23:0];
            avs_pkg::REG_DECAY:    decay_len = value[23:0];
            avs_pkg::REG_SUSTAIN:  sustain = value[15:0];
            avs_pkg::REG_RELEASE:  release_len = value[23:0];
            default: ;
        endcase
    endfunction

    // Quarter-wave polynomial sine in Q15.
    function int sine_q15(bit [31:0] ph);
        bit [TABLE_BITS-1:0] idx;
        bit [1:0] quad;
        longint unsigned x, x2, r, y;
        idx = ph[31 -: TABLE_BITS];
        quad = idx[TABLE_BITS-1 -: 2];
        x = longint'(idx[TABLE_BITS-3:0]) << (30 - (TABLE_BITS - 2));
        if (quad[0]) x = (64'd1 << 30) - x;
        x2 = (x * x) >> 30;
        r = 172272;
        r = 5026995 - ((r * x2) >> 30);
        r = 85569306 - ((r * x2) >> 30);
        r = 693598668 - ((r * x2) >> 30);
        r = 1686629713 - ((r * x2) >> 30);
        y = (r * x) >> 30;
        y = (y + 16384) >> 15;
        if (y > 32767) y = 32767;
        return quad[1] ? -int'(y) : int'(y);
    endfunction

    // Sum of sine partials with 1/n weights, scaled and saturated.
    function int partial_sum(int stride, longint scale);
        longint acc;
        longint v;
        bit [31:0] arg;
        acc = 0;
        for (int n = 1; n <= partials; n += stride) begin
            arg = 32'(n) * phase;
            acc += (longint'(sine_q15(arg)) * 65536) / longint'(n);
        end
        v = (acc * scale) >>> 32;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return int'(v);
    endfunction

    function int wave_value();
        bit lsb;
        case (wave_sel)
            avs_pkg::WAVE_SINE:   return sine_q15(phase);
            avs_pkg::WAVE_SAW:    return partial_sum(1, 41721);
            avs_pkg::WAVE_SQUARE: return partial_sum(2, 83443);
            avs_pkg::WAVE_NOISE: begin
                lsb = lfsr[0];
                lfsr = lfsr >> 1;
                if (lsb) lfsr ^= 32'h8020_0003;
                return int'($signed(lfsr[15:0]));
            end
            default: return 0;
        endcase
    endfunction

    // Updates the voice for one accepted command; ticks queue one sample.
    function void note_input(avs_pkg::t_in cmd);
        longint unsigned freq, rt, stp, lim, t, a, d, s, r, gain;
        int wave, smp;
        avs_pkg::t_out res;
        case (cmd.mode)
            avs_pkg::MODE_NOTE_ON: begin
                freq = octave_hz[cmd.note % 12] >> (10 - cmd.note / 12);
                rt = (rate == 0) ? 1 : rate;
                stp = (freq << 16) / rt;
                lim = (rt << 16) / (2 * freq);
                phase_step = (stp > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : stp[31:0];
                partials = (lim > PARTIAL_CAP) ? 11'(PARTIAL_CAP) : lim[10:0];
                since_start = 0;
                in_release = 0;
                sounding = 1;
            end
            avs_pkg::MODE_NOTE_OFF: begin
                in_release = 1;
                since_release = 0;
            end
            avs_pkg::MODE_TICK: begin
                wave = wave_value();
                phase += phase_step;
                smp = 0;
                gain = 0;
                if (sounding) begin
                    t = since_start; a = attack_len; d = decay_len; s = sustain;
                    if (!in_release) begin
                        if (t < a) gain = t * 65536 / a;
                        else if (t < a + d) gain = 65536 - (t - a) * (65536 - s) / d;
                        else gain = s;
                    end else begin
                        r = since_release;
                        if (r >= release_len) begin
                            sounding = 0;
                            gain = 0;
                        end else begin
                            gain = s - r * s / release_len;
                        end
                        if (since_release != 32'hFFFF_FFFF) since_release++;
                    end
                    smp = int'((longint'(wave) * longint'(gain)) >>> 16);
                    if (!sounding) smp = 0;
                end
                if (since_start != 32'hFFFF_FFFF) since_start++;
                res.sample = smp[15:0];
                res.voice_active = sounding;
                samples_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function void check_result(avs_pkg::t_out got);
        avs_pkg::t_out want;
        if (samples_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: sample %0d active %0b", got.sample,
                         got.voice_active);
            return;
        end
        want = samples_due.pop_front();
        if (got.sample !== want.sample || got.voice_active !== want.voice_active) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: sample exp %0d got %0d, active exp %0b got %0b",
                         want.sample, got.sample, want.voice_active, got.voice_active);
        end
    endfunction
endclass

module additive_oscillator_adsr_voice_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    logic          o_stall;
    avs_pkg::t_in  i_data = '0;
    logic          o_valid;
    logic          i_stall = 1'b0;
    avs_pkg::t_out o_data;
    logic          psel = 1'b0;
    logic          penable = 1'b0;
    logic          pwrite = 1'b0;
    logic [4:0]    paddr = '0;
    logic [31:0]   pwdata = '0;
    logic [31:0]   prdata;
    logic          pready;

    voice_scoreboard sb = new();
    int burst_left = 0;
    int stall_hold = 0;
    int stall_style = 0;

    additive_oscillator_adsr_voice dut (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_data, .o_valid, .i_stall, .o_data,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Result side: check each accepted transaction, then pick the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) sb.check_result(o_data);
        if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            if ($urandom_range(0, 15) == 0) stall_style = $urandom_range(0, 2);
            case (stall_style)
                0: begin
                    i_stall <= 1'b0;
                    stall_hold = $urandom_range(0, 30);
                end
                1: begin
                    i_stall <= ($urandom_range(0, 3) == 0);
                    stall_hold = 0;
                end
                default: begin
                    i_stall <= $urandom_range(0, 1);
                    stall_hold = $urandom_range(1, 25);
                end
            endcase
        end
    end

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 5'(idx) << 2; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, value);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_voice(logic [2:0] wsel, logic [17:0] rt, logic [23:0] att,
                             logic [23:0] dec, logic [15:0] sus, logic [23:0] rel);
        write_reg(avs_pkg::REG_WAVEFORM, 32'(wsel));
        write_reg(avs_pkg::REG_RATE, 32'(rt));
        write_reg(avs_pkg::REG_ATTACK, 32'(att));
        write_reg(avs_pkg::REG_DECAY, 32'(dec));
        write_reg(avs_pkg::REG_SUSTAIN, 32'(sus));
        write_reg(avs_pkg::REG_RELEASE, 32'(rel));
    endtask

    // Command side: bursts of transactions separated by random gaps.
    task automatic send_cmd(logic [1:0] mode, logic [6:0] note);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        i_valid <= 1'b1;
        i_data <= '{mode: mode, note: note};
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input('{mode: mode, note: note});
        burst_left--;
    endtask

    task automatic tick();
        send_cmd(avs_pkg::MODE_TICK, 7'($urandom()));
    endtask

    // Idle the voice: all samples in, then room for a trailing note-on.
    task automatic drain();
        i_valid <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (sb.samples_due.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // One random command; band-limited phases keep notes high so partials stay few.
    task automatic random_cmd(bit band_limited);
        int pick;
        logic [6:0] note;
        pick = $urandom_range(0, 99);
        note = band_limited ? 7'($urandom_range(96, 127)) : 7'($urandom());
        if (pick < 72) tick();
        else if (pick < 84) send_cmd(avs_pkg::MODE_NOTE_ON, note);
        else if (pick < 95) send_cmd(avs_pkg::MODE_NOTE_OFF, 7'($urandom()));
        else send_cmd(avs_pkg::MODE_UNUSED, 7'($urandom()));
    endtask

    initial begin
        logic [2:0]  wsel;
        logic [17:0] rt;
        logic [23:0] att, dec, rel;
        logic [15:0] sus;
        bit          band;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default registers: silent ticks before any note, ignored mode, attack start.
        tick(); tick();
        send_cmd(avs_pkg::MODE_UNUSED, 7'h7F);
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd69);
        repeat (3) tick();
        drain();

        // Short envelope: attack, decay, sustain, release end, repeated note-off.
        set_voice(avs_pkg::WAVE_SINE, 18'd44100, 24'd2, 24'd3, 16'hFFFF, 24'd2);
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd127);
        repeat (6) tick();
        send_cmd(avs_pkg::MODE_NOTE_OFF, 7'd0);
        tick();
        send_cmd(avs_pkg::MODE_NOTE_OFF, 7'd0);
        repeat (4) tick();
        // Release during attack, and release length zero.
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd0);
        tick();
        send_cmd(avs_pkg::MODE_NOTE_OFF, 7'd0);
        repeat (2) tick();
        drain();
        set_voice(avs_pkg::WAVE_NOISE, 18'd8000, 24'd0, 24'd0, 16'd0, 24'd0);
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd127);
        repeat (2) tick();
        send_cmd(avs_pkg::MODE_NOTE_OFF, 7'd0);
        tick();
        drain();

        // Saw above half the rate (no partials, saturated step), then the full partial count.
        set_voice(avs_pkg::WAVE_SAW, 18'd8000, 24'd0, 24'd0, 16'hFFFF, 24'hFFFFFF);
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd127);
        tick();
        drain();
        write_reg(avs_pkg::REG_RATE, 32'd192000);
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd0);
        tick();
        drain();
        write_reg(avs_pkg::REG_WAVEFORM, 32'(avs_pkg::WAVE_SQUARE));
        tick();
        send_cmd(avs_pkg::MODE_NOTE_ON, 7'd120);
        tick();
        drain();

        // Random phases over many voice settings.
        for (int ph = 0; ph < 10; ph++) begin
            wsel = 3'($urandom_range(0, 7));
            if (ph < 8) wsel = 3'(ph);
            band = (wsel == avs_pkg::WAVE_SAW || wsel == avs_pkg::WAVE_SQUARE);
            case ($urandom_range(0, 3))
                0: rt = 18'd8000;
                1: rt = 18'd192000;
                default: rt = 18'($urandom_range(8000, 192000));
            endcase
            att = 24'($urandom_range(0, 20));
            dec = 24'($urandom_range(0, 20));
            rel = 24'($urandom_range(0, 20));
            sus = 16'($urandom());
            if (ph == 3) begin
                att = 24'hFFFFFF; dec = 24'hFFFFFF; rel = 24'hFFFFFF; sus = 16'hFFFF;
            end
            if (ph == 6) sus = 16'd0;
            set_voice(wsel, rt, att, dec, sus, rel);
            send_cmd(avs_pkg::MODE_NOTE_ON,
                     band ? 7'($urandom_range(96, 127)) : 7'($urandom()));
            for (int k = 0; k < 53; k++) random_cmd(band);
            drain();
        end

        if (sb.mismatches == 0) begin
            $display("additive_oscillator_adsr_voice_test: done, clean");
        end else begin
            $display("additive_oscillator_adsr_voice_test: done, errors");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #200ms;
        $display("additive_oscillator_adsr_voice_test: done, errors");
        $finish;
    end
endmodule
